>>> rtl/quaternion_rotation_unit_assert.svh
// Assertion macros for the quaternion rotation unit.
// Used by modules with clk_i and rst_ni in scope; no other dependencies.
`ifndef QUATERNION_ROTATION_UNIT_ASSERT_SVH
`define QUATERNION_ROTATION_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qru_pkg.sv
// Shared types, constants and tables of the quaternion rotation unit.
// No dependencies; used by qru_ctrl, qru_dpath and the top level.
package qru_pkg;

  // CORDIC iteration count, clamped to the arctangent table size
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CordicIter =
    (CORDIC_STEPS > 24) ? 24 : ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
  localparam logic [4:0] CordicLast = 5'(CordicIter - 1);

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] PiQ30      = 34'sd3373259426;
  localparam logic signed [33:0] HalfPiQ30  = 34'sd1686629713;
  localparam logic signed [35:0] OneQ28     = 36'sd268435456;

  // Component indexes
  localparam logic [1:0] IdxS = 2'd0;
  localparam logic [1:0] IdxX = 2'd1;
  localparam logic [1:0] IdxY = 2'd2;
  localparam logic [1:0] IdxZ = 2'd3;

  typedef enum logic [2:0] {
    CMD_LOAD = 3'd0,
    CMD_MUL  = 3'd1,
    CMD_NORM = 3'd2,
    CMD_MAT  = 3'd3,
    CMD_AXIS = 3'd4
  } cmd_e;

  // Second multiplier operand source
  typedef enum logic [1:0] {
    SRC_STATE = 2'd0,
    SRC_IN    = 2'd1,
    SRC_WORK  = 2'd2
  } src_e;

  // One multiply-accumulate term
  typedef struct packed {
    logic       en;
    logic       a_work;
    logic [1:0] a_idx;
    src_e       b_src;
    logic [1:0] b_idx;
    logic       neg;
    logic       dbl;
    logic       one;
  } term_t;

  // Datapath command word
  typedef struct packed {
    logic       ld_in;
    logic       st_from_in;
    logic       st_from_w;
    logic       w_from_state;
    logic       w_from_axis;
    logic       mac_en;
    logic       mac_first;
    term_t      term;
    logic       rnd_wr;
    logic [1:0] widx;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_wr;
    logic       cor_init;
    logic       cor_step;
    logic [4:0] iter;
    logic       scl_wr;
    logic       cos_wr;
    logic       emit_q;
    logic       emit_row;
    logic [1:0] row;
    logic       err;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_zero;
  } dp_stat_t;

  localparam term_t TermNone = '0;

  function automatic term_t mk_term(input logic a_work, input logic [1:0] a,
                                    input src_e bs, input logic [1:0] b,
                                    input logic neg, input logic dbl,
                                    input logic one);
    term_t t;
    t.en     = 1'b1;
    t.a_work = a_work;
    t.a_idx  = a;
    t.b_src  = bs;
    t.b_idx  = b;
    t.neg    = neg;
    t.dbl    = dbl;
    t.one    = one;
    return t;
  endfunction

  // Hamilton product terms: element e, slot k
  function automatic term_t mul_term(input logic [1:0] e, input logic [1:0] k);
    term_t t;
    case ({e, k})
      4'd0:    t = mk_term(1'b0, IdxS, SRC_IN, IdxS, 1'b0, 1'b0, 1'b0);
      4'd1:    t = mk_term(1'b0, IdxX, SRC_IN, IdxX, 1'b1, 1'b0, 1'b0);
      4'd2:    t = mk_term(1'b0, IdxY, SRC_IN, IdxY, 1'b1, 1'b0, 1'b0);
      4'd3:    t = mk_term(1'b0, IdxZ, SRC_IN, IdxZ, 1'b1, 1'b0, 1'b0);
      4'd4:    t = mk_term(1'b0, IdxS, SRC_IN, IdxX, 1'b0, 1'b0, 1'b0);
      4'd5:    t = mk_term(1'b0, IdxX, SRC_IN, IdxS, 1'b0, 1'b0, 1'b0);
      4'd6:    t = mk_term(1'b0, IdxY, SRC_IN, IdxZ, 1'b0, 1'b0, 1'b0);
      4'd7:    t = mk_term(1'b0, IdxZ, SRC_IN, IdxY, 1'b1, 1'b0, 1'b0);
      4'd8:    t = mk_term(1'b0, IdxS, SRC_IN, IdxY, 1'b0, 1'b0, 1'b0);
      4'd9:    t = mk_term(1'b0, IdxY, SRC_IN, IdxS, 1'b0, 1'b0, 1'b0);
      4'd10:   t = mk_term(1'b0, IdxZ, SRC_IN, IdxX, 1'b0, 1'b0, 1'b0);
      4'd11:   t = mk_term(1'b0, IdxX, SRC_IN, IdxZ, 1'b1, 1'b0, 1'b0);
      4'd12:   t = mk_term(1'b0, IdxS, SRC_IN, IdxZ, 1'b0, 1'b0, 1'b0);
      4'd13:   t = mk_term(1'b0, IdxZ, SRC_IN, IdxS, 1'b0, 1'b0, 1'b0);
      4'd14:   t = mk_term(1'b0, IdxX, SRC_IN, IdxY, 1'b0, 1'b0, 1'b0);
      4'd15:   t = mk_term(1'b0, IdxY, SRC_IN, IdxX, 1'b1, 1'b0, 1'b0);
      default: t = TermNone;
    endcase
    return t;
  endfunction

  // Rotation matrix terms (doubled products): row r, column c, slot k
  function automatic term_t mat_term(input logic [1:0] r, input logic [1:0] c,
                                     input logic [1:0] k);
    term_t t;
    if (k[1]) begin
      t = TermNone;
    end else begin
      case ({r, c, k[0]})
        5'b00000: t = mk_term(1'b0, IdxY, SRC_STATE, IdxY, 1'b1, 1'b1, 1'b1);
        5'b00001: t = mk_term(1'b0, IdxZ, SRC_STATE, IdxZ, 1'b1, 1'b1, 1'b0);
        5'b00010: t = mk_term(1'b0, IdxX, SRC_STATE, IdxY, 1'b0, 1'b1, 1'b0);
        5'b00011: t = mk_term(1'b0, IdxS, SRC_STATE, IdxZ, 1'b0, 1'b1, 1'b0);
        5'b00100: t = mk_term(1'b0, IdxX, SRC_STATE, IdxZ, 1'b0, 1'b1, 1'b0);
        5'b00101: t = mk_term(1'b0, IdxS, SRC_STATE, IdxY, 1'b1, 1'b1, 1'b0);
        5'b01000: t = mk_term(1'b0, IdxX, SRC_STATE, IdxY, 1'b0, 1'b1, 1'b0);
        5'b01001: t = mk_term(1'b0, IdxS, SRC_STATE, IdxZ, 1'b1, 1'b1, 1'b0);
        5'b01010: t = mk_term(1'b0, IdxX, SRC_STATE, IdxX, 1'b1, 1'b1, 1'b1);
        5'b01011: t = mk_term(1'b0, IdxZ, SRC_STATE, IdxZ, 1'b1, 1'b1, 1'b0);
        5'b01100: t = mk_term(1'b0, IdxY, SRC_STATE, IdxZ, 1'b0, 1'b1, 1'b0);
        5'b01101: t = mk_term(1'b0, IdxS, SRC_STATE, IdxX, 1'b0, 1'b1, 1'b0);
        5'b10000: t = mk_term(1'b0, IdxX, SRC_STATE, IdxZ, 1'b0, 1'b1, 1'b0);
        5'b10001: t = mk_term(1'b0, IdxS, SRC_STATE, IdxY, 1'b0, 1'b1, 1'b0);
        5'b10010: t = mk_term(1'b0, IdxY, SRC_STATE, IdxZ, 1'b0, 1'b1, 1'b0);
        5'b10011: t = mk_term(1'b0, IdxS, SRC_STATE, IdxX, 1'b1, 1'b1, 1'b0);
        5'b10100: t = mk_term(1'b0, IdxX, SRC_STATE, IdxX, 1'b1, 1'b1, 1'b1);
        5'b10101: t = mk_term(1'b0, IdxY, SRC_STATE, IdxY, 1'b1, 1'b1, 1'b0);
        default:  t = TermNone;
      endcase
    end
    return t;
  endfunction

  // Truncated arctangent table, Q4.30
  function automatic logic signed [33:0] atan_f(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:    v = 34'sh03243F6A8;
      5'd1:    v = 34'sh01DAC6705;
      5'd2:    v = 34'sh00FADBAFC;
      5'd3:    v = 34'sh007F56EA6;
      5'd4:    v = 34'sh003FEAB76;
      5'd5:    v = 34'sh001FFD55B;
      5'd6:    v = 34'sh000FFFAAA;
      5'd7:    v = 34'sh0007FFF55;
      5'd8:    v = 34'sh0003FFFEA;
      5'd9:    v = 34'sh0001FFFFD;
      5'd10:   v = 34'sh0000FFFFF;
      5'd11:   v = 34'sh00007FFFF;
      5'd12:   v = 34'sh00003FFFF;
      5'd13:   v = 34'sh00001FFFF;
      5'd14:   v = 34'sh00000FFFF;
      5'd15:   v = 34'sh000007FFF;
      5'd16:   v = 34'sh000003FFF;
      5'd17:   v = 34'sh000001FFF;
      5'd18:   v = 34'sh000000FFF;
      5'd19:   v = 34'sh0000007FF;
      5'd20:   v = 34'sh0000003FF;
      5'd21:   v = 34'sh0000001FF;
      5'd22:   v = 34'sh0000000FF;
      5'd23:   v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp to signed 16 bits
  function automatic logic signed [15:0] sat16_f(input logic signed [51:0] v);
    if (v > 52'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -52'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

>>> rtl/qru_dpath.sv
// Datapath of the quaternion rotation unit: state, MAC, square root,
// divider, CORDIC and output registers. Depends on qru_pkg.
module qru_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qru_pkg::dp_cmd_t    cmd_i,
  output qru_pkg::dp_stat_t   stat_o,
  input  logic signed [15:0]  in_s_i,
  input  logic signed [15:0]  in_x_i,
  input  logic signed [15:0]  in_y_i,
  input  logic signed [15:0]  in_z_i,
  input  logic signed [15:0]  in_angle_i,
  output logic                out_valid_o,
  output logic                kind_o,
  output logic [1:0]          row_o,
  output logic signed [15:0]  e0_o,
  output logic signed [15:0]  e1_o,
  output logic signed [15:0]  e2_o,
  output logic signed [15:0]  e3_o,
  output logic                error_o,
  output logic                last_o
);

  logic signed [15:0] st_q [4];
  logic signed [15:0] in_q [4];
  logic signed [15:0] w_q  [4];
  logic signed [15:0] ang_q;

  logic signed [35:0] acc_q, acc_d;
  logic [63:0] rad_q;
  logic [35:0] rem_q;
  logic [31:0] root_q;
  logic [46:0] drem_q, ddiv_q;
  logic [14:0] quo_q;
  logic        dsat_q;
  logic signed [33:0] cz_q, cx_q, cy_q;
  logic        cneg_q;

  logic        out_valid_q, kind_q, err_q, last_q;
  logic [1:0]  row_q;
  logic signed [15:0] e_q [4];

  // MAC operands and accumulate
  logic signed [15:0] a_op, b_op;
  logic signed [31:0] prod;
  logic signed [35:0] term_v, base;
  qru_pkg::term_t     tm;

  assign tm = cmd_i.term;

  always_comb begin
    a_op = tm.a_work ? w_q[tm.a_idx] : st_q[tm.a_idx];
    case (tm.b_src)
      qru_pkg::SRC_STATE: b_op = st_q[tm.b_idx];
      qru_pkg::SRC_IN:    b_op = in_q[tm.b_idx];
      qru_pkg::SRC_WORK:  b_op = w_q[tm.b_idx];
      default:            b_op = '0;
    endcase
    prod   = a_op * b_op;
    term_v = tm.dbl ? {{3{prod[31]}}, prod, 1'b0} : {{4{prod[31]}}, prod};
    base   = cmd_i.mac_first ? (tm.one ? qru_pkg::OneQ28 : '0) : acc_q;
    acc_d  = tm.neg ? (base - term_v) : (base + term_v);
  end

  assign stat_o.acc_zero = (acc_q == '0);

  // Q2.14 rounding of the accumulator
  logic signed [51:0] sum14;
  logic signed [15:0] rnd14;
  assign sum14 = {{16{acc_q[35]}}, acc_q} + 52'sd8192;
  assign rnd14 = qru_pkg::sat16_f(sum14 >>> 14);

  // Square root step
  logic [35:0] t_rem, trial;
  assign t_rem = {rem_q[33:0], rad_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};

  // Divider setup and step
  logic signed [15:0] dcomp;
  logic [15:0] mag;
  logic [57:0] num, lim;
  logic        dge;
  logic [15:0] qmag;
  assign dcomp = w_q[cmd_i.widx];
  assign mag   = dcomp[15] ? (~dcomp + 16'd1) : dcomp;
  assign num   = {mag, 42'd0} + {27'd0, root_q[31:1]};
  assign lim   = {11'd0, root_q, 15'd0};
  assign dge   = (drem_q >= ddiv_q);
  assign qmag  = {1'b0, (dsat_q ? 15'h7FFF : quo_q)};

  // CORDIC range reduction, step and outputs
  logic signed [33:0] z0, sx, sy, cos_v, sin_v;
  assign z0    = {{2{ang_q[15]}}, ang_q, 16'd0};
  assign sx    = cx_q >>> cmd_i.iter;
  assign sy    = cy_q >>> cmd_i.iter;
  assign cos_v = cneg_q ? -cx_q : cx_q;
  assign sin_v = cneg_q ? -cy_q : cy_q;

  // Axis scaling by sine, scalar from cosine
  logic [1:0]         wprev;
  logic signed [49:0] sprod;
  logic signed [51:0] sum30, sum16;
  logic signed [15:0] rnd30, rndc;
  assign wprev = cmd_i.widx - 2'd1;
  assign sprod = w_q[wprev] * sin_v;
  assign sum30 = {{2{sprod[49]}}, sprod} + 52'sd536870912;
  assign rnd30 = qru_pkg::sat16_f(sum30 >>> 30);
  assign sum16 = {{18{cos_v[33]}}, cos_v} + 52'sd32768;
  assign rndc  = qru_pkg::sat16_f(sum16 >>> 16);

  // Held quaternion, reset to identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= 16'sd16384;
      st_q[1] <= '0;
      st_q[2] <= '0;
      st_q[3] <= '0;
    end else if (cmd_i.st_from_in) begin
      st_q[0] <= in_s_i;
      st_q[1] <= in_x_i;
      st_q[2] <= in_y_i;
      st_q[3] <= in_z_i;
    end else if (cmd_i.st_from_w) begin
      st_q <= w_q;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit_q | cmd_i.emit_row;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      in_q[0] <= in_s_i;
      in_q[1] <= in_x_i;
      in_q[2] <= in_y_i;
      in_q[3] <= in_z_i;
      ang_q   <= in_angle_i;
    end

    // working vector
    if (cmd_i.w_from_state) begin
      w_q <= st_q;
    end else if (cmd_i.w_from_axis) begin
      w_q[0] <= in_x_i;
      w_q[1] <= in_y_i;
      w_q[2] <= in_z_i;
      w_q[3] <= '0;
    end else if (cmd_i.rnd_wr) begin
      w_q[cmd_i.widx] <= rnd14;
    end else if (cmd_i.div_wr) begin
      w_q[cmd_i.widx] <= dcomp[15] ? (~qmag + 16'd1) : qmag;
    end else if (cmd_i.scl_wr) begin
      w_q[cmd_i.widx] <= rnd30;
    end else if (cmd_i.cos_wr) begin
      w_q[0] <= rndc;
    end

    if (cmd_i.mac_en) begin
      acc_q <= acc_d;
    end

    // restoring square root, one result bit per cycle
    if (cmd_i.sqrt_init) begin
      rad_q  <= {acc_q, 28'd0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (t_rem >= trial) begin
        rem_q  <= t_rem - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= t_rem;
        root_q <= {root_q[30:0], 1'b0};
      end
    end

    // restoring divider, one quotient bit per cycle
    if (cmd_i.div_init) begin
      dsat_q <= (num >= lim);
      drem_q <= num[46:0];
      ddiv_q <= {1'b0, root_q, 14'd0};
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (dge) begin
        drem_q <= drem_q - ddiv_q;
      end
      ddiv_q <= {1'b0, ddiv_q[46:1]};
      quo_q  <= {quo_q[13:0], dge};
    end

    // CORDIC rotation
    if (cmd_i.cor_init) begin
      cx_q <= qru_pkg::CordicGain;
      cy_q <= '0;
      if (z0 > qru_pkg::HalfPiQ30) begin
        cz_q   <= z0 - qru_pkg::PiQ30;
        cneg_q <= 1'b1;
      end else if (z0 < -qru_pkg::HalfPiQ30) begin
        cz_q   <= z0 + qru_pkg::PiQ30;
        cneg_q <= 1'b1;
      end else begin
        cz_q   <= z0;
        cneg_q <= 1'b0;
      end
    end else if (cmd_i.cor_step) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - sy;
        cy_q <= cy_q + sx;
        cz_q <= cz_q - qru_pkg::atan_f(cmd_i.iter);
      end else begin
        cx_q <= cx_q + sy;
        cy_q <= cy_q - sx;
        cz_q <= cz_q + qru_pkg::atan_f(cmd_i.iter);
      end
    end

    // result fields
    if (cmd_i.emit_q) begin
      kind_q <= 1'b0;
      row_q  <= '0;
      e_q    <= st_q;
      err_q  <= cmd_i.err;
      last_q <= 1'b1;
    end else if (cmd_i.emit_row) begin
      kind_q <= 1'b1;
      row_q  <= cmd_i.row;
      e_q[0] <= w_q[0];
      e_q[1] <= w_q[1];
      e_q[2] <= w_q[2];
      e_q[3] <= '0;
      err_q  <= 1'b0;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign row_o       = row_q;
  assign e0_o        = e_q[0];
  assign e1_o        = e_q[1];
  assign e2_o        = e_q[2];
  assign e3_o        = e_q[3];
  assign error_o     = err_q;
  assign last_o      = last_q;

endmodule

>>> rtl/qru_ctrl.sv
// Controller of the quaternion rotation unit: sequences the datapath per command.
// Depends on qru_pkg and quaternion_rotation_unit_assert.svh.
`include "quaternion_rotation_unit_assert.svh"

module qru_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2:0]        command_i,
  input  qru_pkg::dp_stat_t stat_i,
  output logic              busy_o,
  output qru_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_MAC    = 16'h0002,
    S_RND    = 16'h0004,
    S_ROW    = 16'h0008,
    S_SQ     = 16'h0010,
    S_CHK    = 16'h0020,
    S_SQRT   = 16'h0040,
    S_DINIT  = 16'h0080,
    S_DIV    = 16'h0100,
    S_DWR    = 16'h0200,
    S_CINIT  = 16'h0400,
    S_CSTEP  = 16'h0800,
    S_SCALE  = 16'h1000,
    S_COSW   = 16'h2000,
    S_COMMIT = 16'h4000,
    S_EMIT   = 16'h8000
  } state_e;

  state_e     st_q, st_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] col_q, col_d;
  logic [1:0] row_q, row_d;
  logic       mat_q, mat_d;
  logic       ph_q, ph_d;
  logic       err_q, err_d;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      col_q <= '0;
      row_q <= '0;
      mat_q <= 1'b0;
      ph_q  <= 1'b0;
      err_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      col_q <= col_d;
      row_q <= row_d;
      mat_q <= mat_d;
      ph_q  <= ph_d;
      err_q <= err_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    col_d = col_q;
    row_d = row_q;
    mat_d = mat_q;
    ph_d  = ph_q;
    err_d = err_q;
    cmd_o = '0;
    cmd_o.widx = col_q;
    cmd_o.iter = cnt_q;
    cmd_o.row  = row_q;
    cmd_o.err  = err_q;
    cmd_o.last = (row_q == 2'd2);

    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.ld_in = 1'b1;
          cnt_d = '0;
          col_d = '0;
          row_d = '0;
          err_d = 1'b0;
          case (command_i)
            qru_pkg::CMD_LOAD: begin
              cmd_o.st_from_in = 1'b1;
              st_d = S_EMIT;
            end
            qru_pkg::CMD_MUL: begin
              mat_d = 1'b0;
              st_d  = S_MAC;
            end
            qru_pkg::CMD_NORM: begin
              cmd_o.w_from_state = 1'b1;
              ph_d = 1'b1;
              st_d = S_SQ;
            end
            qru_pkg::CMD_MAT: begin
              mat_d = 1'b1;
              st_d  = S_MAC;
            end
            qru_pkg::CMD_AXIS: begin
              cmd_o.w_from_axis = 1'b1;
              ph_d = 1'b0;
              st_d = S_SQ;
            end
            default: st_d = S_IDLE;
          endcase
        end
      end

      // sum of product terms for one element
      S_MAC: begin
        cmd_o.mac_en    = 1'b1;
        cmd_o.mac_first = (cnt_q == 5'd0);
        cmd_o.term = mat_q ? qru_pkg::mat_term(row_q, col_q, cnt_q[1:0])
                           : qru_pkg::mul_term(col_q, cnt_q[1:0]);
        if (cnt_q[1:0] == (mat_q ? 2'd1 : 2'd3)) begin
          cnt_d = '0;
          st_d  = S_RND;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end

      S_RND: begin
        cmd_o.rnd_wr = 1'b1;
        if (mat_q) begin
          if (col_q == 2'd2) begin
            col_d = '0;
            st_d  = S_ROW;
          end else begin
            col_d = col_q + 2'd1;
            st_d  = S_MAC;
          end
        end else if (col_q == 2'd3) begin
          st_d = S_COMMIT;
        end else begin
          col_d = col_q + 2'd1;
          st_d  = S_MAC;
        end
      end

      S_ROW: begin
        cmd_o.emit_row = 1'b1;
        if (row_q == 2'd2) begin
          st_d = S_IDLE;
        end else begin
          row_d = row_q + 2'd1;
          st_d  = S_MAC;
        end
      end

      // sum of squares of the working vector
      S_SQ: begin
        cmd_o.mac_en    = 1'b1;
        cmd_o.mac_first = (cnt_q == 5'd0);
        cmd_o.term = qru_pkg::mk_term(1'b1, cnt_q[1:0], qru_pkg::SRC_WORK,
                                      cnt_q[1:0], 1'b0, 1'b0, 1'b0);
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d = '0;
          st_d  = S_CHK;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end

      // zero length is refused with the state left as it was
      S_CHK: begin
        if (stat_i.acc_zero) begin
          err_d = 1'b1;
          st_d  = S_EMIT;
        end else begin
          cmd_o.sqrt_init = 1'b1;
          cnt_d = '0;
          st_d  = S_SQRT;
        end
      end

      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          col_d = '0;
          st_d  = S_DINIT;
        end
      end

      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d = '0;
        st_d  = S_DIV;
      end

      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd14) begin
          st_d = S_DWR;
        end
      end

      S_DWR: begin
        cmd_o.div_wr = 1'b1;
        if (col_q == 2'd3) begin
          st_d = ph_q ? S_COMMIT : S_CINIT;
        end else begin
          col_d = col_q + 2'd1;
          st_d  = S_DINIT;
        end
      end

      S_CINIT: begin
        cmd_o.cor_init = 1'b1;
        cnt_d = '0;
        st_d  = S_CSTEP;
      end

      S_CSTEP: begin
        cmd_o.cor_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == qru_pkg::CordicLast) begin
          col_d = 2'd3;
          st_d  = S_SCALE;
        end
      end

      // vector part from the normalized axis, top component first
      S_SCALE: begin
        cmd_o.scl_wr = 1'b1;
        if (col_q == 2'd1) begin
          st_d = S_COSW;
        end else begin
          col_d = col_q - 2'd1;
        end
      end

      S_COSW: begin
        cmd_o.cos_wr = 1'b1;
        ph_d  = 1'b1;
        cnt_d = '0;
        st_d  = S_SQ;
      end

      S_COMMIT: begin
        cmd_o.st_from_w = 1'b1;
        st_d = S_EMIT;
      end

      S_EMIT: begin
        cmd_o.emit_q = 1'b1;
        st_d = S_IDLE;
      end

      default: st_d = S_IDLE;
    endcase
  end

  assign busy_o = (st_q != S_IDLE);

  `QRU_ASSERT_NEXT(a_mul_entry, (st_q == S_IDLE) && start_i && (command_i == qru_pkg::CMD_MUL), st_q == S_MAC, "multiply did not start accumulating")
  `QRU_ASSERT_NEXT(a_zero_refused, (st_q == S_CHK) && stat_i.acc_zero, (st_q == S_EMIT) && err_q, "zero length not refused")
  `QRU_ASSERT_NEXT(a_last_row_ends, (st_q == S_ROW) && (row_q == 2'd2), (st_q == S_IDLE) && !busy_o, "matrix did not end after last row")

endmodule

>>> rtl/quaternion_rotation_unit.sv
// Top level of the quaternion rotation unit: controller plus datapath.
// Depends on qru_pkg, qru_ctrl and qru_dpath.
//
//   channel   direction  handshake               fields
//   command   in         start_i & !busy_o       command_i, in_s/x/y/z_i, in_angle_i
//   result    out        out_valid_o (1 cycle)   kind_o, row_o, e0..e3_o, error_o, last_o
//
// The square root (32 steps) and the divider (once per component) do most
// of the work of normalize and of angle and axis, with 16 CORDIC steps.
// The registered result strobe rises in the cycle after S_EMIT or S_ROW;
// busy_o is low then, but for the first two rows of a matrix.
// Reset (rst_ni low) loads the identity quaternion and drops all strobes.
// The result receiver cannot stall.
module quaternion_rotation_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         command_i,
  input  logic signed [15:0] in_s_i,
  input  logic signed [15:0] in_x_i,
  input  logic signed [15:0] in_y_i,
  input  logic signed [15:0] in_z_i,
  input  logic signed [15:0] in_angle_i,
  output logic               out_valid_o,
  output logic               kind_o,
  output logic [1:0]         row_o,
  output logic signed [15:0] e0_o,
  output logic signed [15:0] e1_o,
  output logic signed [15:0] e2_o,
  output logic signed [15:0] e3_o,
  output logic               error_o,
  output logic               last_o
);

  qru_pkg::dp_cmd_t  dp_cmd;
  qru_pkg::dp_stat_t dp_stat;

  // Command sequencer
  qru_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .busy_o    (busy_o),
    .cmd_o     (dp_cmd)
  );

  // Arithmetic and result registers
  qru_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .in_s_i      (in_s_i),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .in_angle_i  (in_angle_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .row_o       (row_o),
    .e0_o        (e0_o),
    .e1_o        (e1_o),
    .e2_o        (e2_o),
    .e3_o        (e3_o),
    .error_o     (error_o),
    .last_o      (last_o)
  );

endmodule
